@@ hw/rtl/rps_pkg.sv @@
`timescale 1ns / 1ps
// Rail patrol speed sequencer: shared types, codes and speed constants.
// No dependencies; used by rps_tick and rail_patrol_speed_sequencer_core.

package rps_pkg;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_LEFT_SLOW_EDGE        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RIGHT_SLOW_EDGE       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FEINT_POINT_RIGHTWARD = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FEINT_POINT_LEFTWARD  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_PAUSE_TICKS           = 3'd4;

   // Register reset values
   localparam logic [15:0] LEFT_SLOW_EDGE_RST        = 16'd4000;
   localparam logic [15:0] RIGHT_SLOW_EDGE_RST       = 16'd18469;
   localparam logic [15:0] FEINT_POINT_RIGHTWARD_RST = 16'd14200;
   localparam logic [15:0] FEINT_POINT_LEFTWARD_RST  = 16'd9000;
   localparam logic [15:0] PAUSE_TICKS_RST           = 16'd100;

   // End sensor and limit switch codes
   localparam logic [1:0] ES_IDLE  = 2'd0;
   localparam logic [1:0] ES_LEFT  = 2'd1;
   localparam logic [1:0] ES_RIGHT = 2'd2;
   localparam logic [1:0] LS_LEFT  = 2'd1;
   localparam logic [1:0] LS_RIGHT = 2'd2;

   // Speed magnitudes
   localparam logic [12:0] SPEED_BASE  = 13'd1500;
   localparam logic [12:0] SPEED_FEINT = 13'd1800;
   localparam logic [12:0] SPEED_2000  = 13'd2000;
   localparam logic [12:0] SPEED_2400  = 13'd2400;
   localparam logic [12:0] SPEED_2500  = 13'd2500;
   localparam logic [12:0] SPEED_3000  = 13'd3000;
   localparam logic [12:0] SPEED_3200  = 13'd3200;
   localparam logic [12:0] SPEED_3600  = 13'd3600;
   localparam logic [12:0] SPEED_4000  = 13'd4000;
   localparam logic [12:0] SPEED_4200  = 13'd4200;
   localparam logic [12:0] SPEED_4300  = 13'd4300;
   localparam logic [12:0] SPEED_4800  = 13'd4800;
   localparam logic [12:0] SPEED_MAX   = 13'd5200;

   // Run ramp thresholds
   localparam logic [15:0] RUN_T60  = 16'd60;
   localparam logic [15:0] RUN_T100 = 16'd100;
   localparam logic [15:0] RUN_T200 = 16'd200;
   localparam logic [15:0] RUN_T300 = 16'd300;
   localparam logic [15:0] RUN_T350 = 16'd350;
   localparam logic [15:0] RUN_T480 = 16'd480;
   localparam logic [15:0] RUN_T810 = 16'd810;

   // Feint timing
   localparam logic [10:0] FEINT_TURN_TICKS = 11'd50;
   localparam logic [10:0] FEINT_T100       = 11'd100;
   localparam logic [10:0] FEINT_T200       = 11'd200;
   localparam logic [10:0] FEINT_T300       = 11'd300;
   localparam logic [10:0] FEINT_T400       = 11'd400;
   localparam logic [10:0] FEINT_T500       = 11'd500;
   localparam logic [10:0] FEINT_T600       = 11'd600;
   localparam logic [10:0] FEINT_T700       = 11'd700;
   localparam logic [10:0] FEINT_END_TICKS  = 11'd1000;

   typedef struct packed {
      logic [15:0] left_slow_edge;
      logic [15:0] right_slow_edge;
      logic [15:0] feint_point_rightward;
      logic [15:0] feint_point_leftward;
      logic [15:0] pause_ticks;
   } rps_cfg_type;

   typedef struct packed {
      logic [1:0]  end_sensors;
      logic [1:0]  limit_switch;
      logic [15:0] rail_position;
      logic        coin_rightward;
      logic        coin_leftward;
      logic        drive_enable;
   } rps_item_type;

   typedef struct packed {
      logic signed [13:0] speed_setpoint;
      logic               drive_active;
   } rps_result_type;

   typedef struct packed {
      logic [15:0]        pause_count;
      logic [15:0]        run_count;
      logic               heading_left;
      logic signed [13:0] held_setpoint;
      logic [15:0]        previous_position;
      logic               feint_right_busy;
      logic [10:0]        feint_right_count;
      logic               feint_left_busy;
      logic [10:0]        feint_left_count;
   } rps_state_type;

   function automatic logic signed [13:0] to_speed(input logic heading_left,
                                                   input logic [12:0] mag);
      logic signed [13:0] m;
      m = signed'({1'b0, mag});
      return heading_left ? -m : m;
   endfunction

endpackage

@@ hw/rtl/rps_tick.sv @@
`timescale 1ns / 1ps
// Next-state and result logic for one tick of the rail patrol sequencer.
// Depends on rps_pkg. Purely combinational; registered by the top level.

module rps_tick (
   input  rps_pkg::rps_cfg_type    cfg_i,
   input  rps_pkg::rps_state_type  state_i,
   input  rps_pkg::rps_item_type   item_i,
   output rps_pkg::rps_state_type  state_o,
   output rps_pkg::rps_result_type result_o
);

   function automatic logic [12:0] feint_mag(input logic [10:0] c);
      logic [12:0] m;
      m = '0;
      if      (c > rps_pkg::FEINT_T700) m = rps_pkg::SPEED_MAX;
      else if (c > rps_pkg::FEINT_T600) m = rps_pkg::SPEED_4800;
      else if (c > rps_pkg::FEINT_T500) m = rps_pkg::SPEED_4200;
      else if (c > rps_pkg::FEINT_T400) m = rps_pkg::SPEED_3600;
      else if (c > rps_pkg::FEINT_T300) m = rps_pkg::SPEED_3000;
      else if (c > rps_pkg::FEINT_T200) m = rps_pkg::SPEED_2400;
      else if (c > rps_pkg::FEINT_T100) m = rps_pkg::SPEED_FEINT;
      return m;
   endfunction

   function automatic logic [16:0] sat_inc16(input logic [15:0] v);
      logic [16:0] r;
      r = {1'b0, (v == '1) ? v : v + 16'd1};
      return r;
   endfunction

   function automatic logic [10:0] sat_inc11(input logic [10:0] v);
      return (v == '1) ? v : v + 11'd1;
   endfunction

   logic [15:0]           pos;
   logic                  seg_left;
   logic                  seg_right;
   logic                  ramp_hit;
   logic [12:0]           ramp_mag;
   logic [16:0]           run_inc;
   logic [16:0]           pause_inc;
   rps_pkg::rps_state_type nxt;

   assign pos       = item_i.rail_position;
   assign seg_left  = pos < cfg_i.left_slow_edge;
   assign seg_right = !seg_left && (pos > cfg_i.right_slow_edge);
   assign run_inc   = sat_inc16(state_i.run_count);
   assign pause_inc = sat_inc16(state_i.pause_count);

   always_comb begin
      nxt = state_i;

      // pause / run counters and heading from end sensors
      if (item_i.end_sensors == rps_pkg::ES_IDLE) begin
         nxt.pause_count = '0;
         nxt.run_count   = run_inc[15:0];
      end else if (item_i.end_sensors == rps_pkg::ES_LEFT ||
                   item_i.limit_switch == rps_pkg::LS_LEFT) begin
         nxt.pause_count  = pause_inc[15:0];
         nxt.run_count    = '0;
         nxt.heading_left = 1'b0;
      end else if (item_i.end_sensors == rps_pkg::ES_RIGHT ||
                   item_i.limit_switch == rps_pkg::LS_RIGHT) begin
         nxt.pause_count  = pause_inc[15:0];
         nxt.run_count    = '0;
         nxt.heading_left = 1'b1;
      end else begin
         nxt.pause_count = 16'd1;
         nxt.run_count   = '0;
      end

      // run ramp
      ramp_hit = 1'b1;
      ramp_mag = rps_pkg::SPEED_2000;
      if (nxt.run_count > rps_pkg::RUN_T480 && nxt.run_count < rps_pkg::RUN_T810)
         ramp_mag = rps_pkg::SPEED_MAX;
      else if (nxt.run_count > rps_pkg::RUN_T350) ramp_mag = rps_pkg::SPEED_4300;
      else if (nxt.run_count > rps_pkg::RUN_T300) ramp_mag = rps_pkg::SPEED_4000;
      else if (nxt.run_count > rps_pkg::RUN_T200) ramp_mag = rps_pkg::SPEED_3200;
      else if (nxt.run_count > rps_pkg::RUN_T100) ramp_mag = rps_pkg::SPEED_2500;
      else if (nxt.run_count > rps_pkg::RUN_T60)  ramp_mag = rps_pkg::SPEED_2000;
      else ramp_hit = 1'b0;

      if (nxt.pause_count != '0 && nxt.pause_count < cfg_i.pause_ticks &&
          nxt.run_count == '0) begin
         nxt.held_setpoint = '0;
      end else if (nxt.pause_count > cfg_i.pause_ticks && nxt.run_count == '0) begin
         nxt.held_setpoint = rps_pkg::to_speed(nxt.heading_left, rps_pkg::SPEED_BASE);
      end else if (nxt.pause_count == '0 && ramp_hit) begin
         nxt.held_setpoint = rps_pkg::to_speed(nxt.heading_left, ramp_mag);
      end

      // rightward feint: turns to the left
      if (item_i.coin_rightward) begin
         if (state_i.previous_position < cfg_i.feint_point_rightward &&
             pos >= cfg_i.feint_point_rightward &&
             !nxt.heading_left && !nxt.feint_right_busy) begin
            nxt.feint_right_count = '0;
            nxt.held_setpoint     = rps_pkg::to_speed(nxt.heading_left,
                                                      rps_pkg::SPEED_FEINT);
            nxt.feint_right_busy  = 1'b1;
         end
         if (nxt.feint_right_busy) begin
            nxt.feint_right_count = sat_inc11(nxt.feint_right_count);
            if (nxt.feint_right_count > rps_pkg::FEINT_TURN_TICKS) begin
               nxt.heading_left  = 1'b1;
               nxt.held_setpoint = rps_pkg::to_speed(1'b1,
                                                     feint_mag(nxt.feint_right_count));
            end
         end
         if (nxt.feint_right_count > rps_pkg::FEINT_END_TICKS) begin
            nxt.feint_right_busy  = 1'b0;
            nxt.feint_right_count = '0;
         end
      end

      // leftward feint: turns to the right
      if (item_i.coin_leftward) begin
         if (state_i.previous_position >= cfg_i.feint_point_leftward &&
             pos < cfg_i.feint_point_leftward &&
             nxt.heading_left && !nxt.feint_left_busy) begin
            nxt.feint_left_count = '0;
            nxt.held_setpoint    = rps_pkg::to_speed(nxt.heading_left,
                                                     rps_pkg::SPEED_FEINT);
            nxt.feint_left_busy  = 1'b1;
         end
         if (nxt.feint_left_busy) begin
            nxt.feint_left_count = sat_inc11(nxt.feint_left_count);
            if (nxt.feint_left_count > rps_pkg::FEINT_TURN_TICKS) begin
               nxt.heading_left  = 1'b0;
               nxt.held_setpoint = rps_pkg::to_speed(1'b0,
                                                     feint_mag(nxt.feint_left_count));
            end
         end
         if (nxt.feint_left_count > rps_pkg::FEINT_END_TICKS) begin
            nxt.feint_left_busy  = 1'b0;
            nxt.feint_left_count = '0;
         end
      end

      // end segment clamp
      if (nxt.heading_left && seg_left)
         nxt.held_setpoint = rps_pkg::to_speed(1'b1, rps_pkg::SPEED_BASE);
      if (!nxt.heading_left && seg_right)
         nxt.held_setpoint = rps_pkg::to_speed(1'b0, rps_pkg::SPEED_BASE);

      if (!item_i.drive_enable) nxt.run_count = '0;
      nxt.previous_position = pos;

      state_o = nxt;
      result_o.speed_setpoint = item_i.drive_enable ? nxt.held_setpoint : 14'sd0;
      result_o.drive_active   = item_i.drive_enable;
   end

endmodule

@@ hw/rtl/rail_patrol_speed_sequencer_core.sv @@
`timescale 1ns / 1ps
// Rail patrol speed sequencer, top level: stream ports, config registers,
// input and result registers. Depends on rps_pkg and rps_tick.

// One transaction per control tick turns end-sensor, limit, position, coin and
// enable bits into a signed wheel speed setpoint and an active flag. The block
// takes a new transaction every clock cycle while rsp_ is not back-pressured;
// each result passes the input register, the tick logic and then the result
// register. Back-pressure on rsp_ stalls the input register, which in turn
// drops req_tready. The user must write config registers through csr_ only
// while no transaction is in flight; the block itself does not enforce it.

module rail_patrol_speed_sequencer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] end_sensors, [3:2] limit_switch, [19:4] rail_position,
   // [20] coin_rightward, [21] coin_leftward, [22] drive_enable, [23] zero
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [13:0] speed_setpoint (signed), [14] drive_active, [15] zero
   output logic [15:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [rps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0] csr_wdata
);

   rps_pkg::rps_cfg_type    cfg_ff, cfg_in;
   rps_pkg::rps_state_type  state_ff, state_in, state_next;
   rps_pkg::rps_item_type   item_ff, item_in;
   rps_pkg::rps_result_type result_ff, result_in, result_next;
   logic                    in_valid_ff, in_valid_in;
   logic                    out_valid_ff, out_valid_in;
   logic                    advance;
   logic                    req_take;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, result_ff.drive_active, result_ff.speed_setpoint};

   rps_tick u_tick (
      .cfg_i    (cfg_ff),
      .state_i  (state_ff),
      .item_i   (item_ff),
      .state_o  (state_next),
      .result_o (result_next)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            rps_pkg::REG_LEFT_SLOW_EDGE:        cfg_in.left_slow_edge        = csr_wdata;
            rps_pkg::REG_RIGHT_SLOW_EDGE:       cfg_in.right_slow_edge       = csr_wdata;
            rps_pkg::REG_FEINT_POINT_RIGHTWARD: cfg_in.feint_point_rightward = csr_wdata;
            rps_pkg::REG_FEINT_POINT_LEFTWARD:  cfg_in.feint_point_leftward  = csr_wdata;
            rps_pkg::REG_PAUSE_TICKS:           cfg_in.pause_ticks           = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      item_in.end_sensors    = req_tdata[1:0];
      item_in.limit_switch   = req_tdata[3:2];
      item_in.rail_position  = req_tdata[19:4];
      item_in.coin_rightward = req_tdata[20];
      item_in.coin_leftward  = req_tdata[21];
      item_in.drive_enable   = req_tdata[22];
      if (!req_take) item_in = item_ff;

      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
      state_in     = advance ? state_next : state_ff;
      result_in    = advance ? result_next : result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left_slow_edge        <= rps_pkg::LEFT_SLOW_EDGE_RST;
         cfg_ff.right_slow_edge       <= rps_pkg::RIGHT_SLOW_EDGE_RST;
         cfg_ff.feint_point_rightward <= rps_pkg::FEINT_POINT_RIGHTWARD_RST;
         cfg_ff.feint_point_leftward  <= rps_pkg::FEINT_POINT_LEFTWARD_RST;
         cfg_ff.pause_ticks           <= rps_pkg::PAUSE_TICKS_RST;
         state_ff                     <= '0;
         in_valid_ff                  <= 1'b0;
         out_valid_ff                 <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      result_ff <= result_in;
   end

   // a feint counter only runs while its feint is busy
   a_right_count_idle: assert property (@(posedge clock) disable iff (reset)
      !state_ff.feint_right_busy |-> state_ff.feint_right_count == '0)
      else $error("right feint count nonzero while idle");

   a_left_count_idle: assert property (@(posedge clock) disable iff (reset)
      !state_ff.feint_left_busy |-> state_ff.feint_left_count == '0)
      else $error("left feint count nonzero while idle");

   a_inactive_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !result_ff.drive_active |-> result_ff.speed_setpoint == 14'sd0)
      else $error("nonzero setpoint while drive inactive");

   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (result_ff.speed_setpoint <= 14'sd5200 &&
                        result_ff.speed_setpoint >= -14'sd5200))
      else $error("setpoint out of range");

   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |=> $stable(state_ff))
      else $error("sequencer state moved during output stall");

endmodule

@@ sim/rail_patrol_speed_sequencer_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for rail_patrol_speed_sequencer_core: a directed tick table, then
// random patrol episodes over several register settings, checked against a local predictor or,
// for pinned table rows, the pinned result. Depends on rps_pkg and the core RTL.

module rail_patrol_speed_sequencer_core_tb;
   import rps_pkg::*;

   localparam logic [1:0] ES_BOTH = 2'd3;
   localparam logic [1:0] LS_NONE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 3'd5;

   typedef enum logic [1:0] {SEG_LEFT, SEG_MID, SEG_RIGHT} rail_segment_t;

   typedef struct packed {
      rps_item_type   tick;
      logic [31:0]    reps;
      logic           pinned;
      rps_result_type pin;
   } plan_row_t;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // predictor copy of registers and state
   logic [15:0]        cfg_left_edge, cfg_right_edge, cfg_point_right, cfg_point_left;
   logic [15:0]        cfg_pause_len;
   logic [15:0]        pause_cnt, run_cnt, last_pos;
   logic               head_left, feint_r_busy, feint_l_busy;
   logic [10:0]        feint_r_cnt, feint_l_cnt;
   logic signed [13:0] held_sp;

   rps_result_type setpoint_queue[$];
   rps_result_type oldest_setpoint;
   plan_row_t      tick_plan[$];
   int             fault_count = 0;
   int             rsp_stall_max = 0;

   rail_patrol_speed_sequencer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic signed [13:0] toward(input logic [12:0] mag);
      int v;
      v = mag;
      if (head_left) v = -v;
      return v[13:0];
   endfunction

   task automatic feint_step(inout logic busy, inout logic [10:0] cnt, input logic turn_left);
      if (busy) begin
         if (cnt != 11'h7FF) cnt = cnt + 11'd1;
         if (cnt > FEINT_TURN_TICKS) begin
            held_sp   = '0;
            head_left = turn_left;
         end
         if (cnt > FEINT_T100) held_sp = toward(SPEED_FEINT);
         if (cnt > FEINT_T200) held_sp = toward(SPEED_2400);
         if (cnt > FEINT_T300) held_sp = toward(SPEED_3000);
         if (cnt > FEINT_T400) held_sp = toward(SPEED_3600);
         if (cnt > FEINT_T500) held_sp = toward(SPEED_4200);
         if (cnt > FEINT_T600) held_sp = toward(SPEED_4800);
         if (cnt > FEINT_T700) held_sp = toward(SPEED_MAX);
      end
      if (cnt > FEINT_END_TICKS) begin
         busy = 1'b0;
         cnt  = '0;
      end
   endtask

   task automatic predict_setpoint(input rps_item_type it, output rps_result_type res);
      rail_segment_t seg;
      if (it.end_sensors == ES_IDLE) begin
         pause_cnt = '0;
         if (run_cnt != 16'hFFFF) run_cnt = run_cnt + 16'd1;
      end else if (it.end_sensors == ES_LEFT || it.limit_switch == LS_LEFT) begin
         if (pause_cnt != 16'hFFFF) pause_cnt = pause_cnt + 16'd1;
         run_cnt   = '0;
         head_left = 1'b0;
      end else if (it.end_sensors == ES_RIGHT || it.limit_switch == LS_RIGHT) begin
         if (pause_cnt != 16'hFFFF) pause_cnt = pause_cnt + 16'd1;
         run_cnt   = '0;
         head_left = 1'b1;
      end else begin
         pause_cnt = 16'd1;
         run_cnt   = '0;
      end

      if (it.rail_position < cfg_left_edge) seg = SEG_LEFT;
      else if (it.rail_position <= cfg_right_edge) seg = SEG_MID;
      else seg = SEG_RIGHT;

      if (pause_cnt != 0 && pause_cnt < cfg_pause_len && run_cnt == 0) begin
         held_sp = '0;
      end else if (pause_cnt > cfg_pause_len && run_cnt == 0) begin
         held_sp = toward(SPEED_BASE);
      end else if (pause_cnt == 0) begin
         if (run_cnt > RUN_T60)  held_sp = toward(SPEED_2000);
         if (run_cnt > RUN_T100) held_sp = toward(SPEED_2500);
         if (run_cnt > RUN_T200) held_sp = toward(SPEED_3200);
         if (run_cnt > RUN_T300) held_sp = toward(SPEED_4000);
         if (run_cnt > RUN_T350) held_sp = toward(SPEED_4300);
         if (run_cnt > RUN_T480 && run_cnt < RUN_T810) held_sp = toward(SPEED_MAX);
      end

      if (it.coin_rightward) begin
         if (last_pos < cfg_point_right && it.rail_position >= cfg_point_right
             && !head_left && !feint_r_busy) begin
            feint_r_cnt  = '0;
            held_sp      = toward(SPEED_FEINT);
            feint_r_busy = 1'b1;
         end
         feint_step(feint_r_busy, feint_r_cnt, 1'b1);
      end
      if (it.coin_leftward) begin
         if (last_pos >= cfg_point_left && it.rail_position < cfg_point_left
             && head_left && !feint_l_busy) begin
            feint_l_cnt  = '0;
            held_sp      = toward(SPEED_FEINT);
            feint_l_busy = 1'b1;
         end
         feint_step(feint_l_busy, feint_l_cnt, 1'b0);
      end

      if (head_left && seg == SEG_LEFT) held_sp = toward(SPEED_BASE);
      if (!head_left && seg == SEG_RIGHT) held_sp = toward(SPEED_BASE);

      if (!it.drive_enable) run_cnt = '0;
      last_pos = it.rail_position;

      res.speed_setpoint = it.drive_enable ? held_sp : 14'sd0;
      res.drive_active   = it.drive_enable;
   endtask

   task automatic send_tick(input rps_item_type it, input int gap, input logic pinned,
                            input rps_result_type pin);
      rps_result_type res;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, it.drive_enable, it.coin_leftward, it.coin_rightward,
                     it.rail_position, it.limit_switch, it.end_sensors};
      do @(posedge clock); while (!req_tready);
      predict_setpoint(it, res);
      setpoint_queue.push_back(pinned ? pin : res);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (setpoint_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_put(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         REG_LEFT_SLOW_EDGE:        cfg_left_edge   = val;
         REG_RIGHT_SLOW_EDGE:       cfg_right_edge  = val;
         REG_FEINT_POINT_RIGHTWARD: cfg_point_right = val;
         REG_FEINT_POINT_LEFTWARD:  cfg_point_left  = val;
         REG_PAUSE_TICKS:           cfg_pause_len   = val;
         default: ;
      endcase
   endtask

   task automatic load_settings(input logic [15:0] left_edge, right_edge, point_right,
                                input logic [15:0] point_left, pause_len);
      csr_put(REG_LEFT_SLOW_EDGE, left_edge);
      csr_put(REG_RIGHT_SLOW_EDGE, right_edge);
      csr_put(REG_FEINT_POINT_RIGHTWARD, point_right);
      csr_put(REG_FEINT_POINT_LEFTWARD, point_left);
      csr_put(REG_PAUSE_TICKS, pause_len);
      // unmapped index, must leave everything alone
      csr_put(REG_UNUSED, 16'($urandom));
      csr_we <= 1'b0;
   endtask

   task automatic plan_row(input logic [1:0] es, ls, input logic [15:0] pos,
                           input logic cr, cl, en, input int reps,
                           input logic pinned, input int speed, input logic active);
      plan_row_t row;
      row.tick.end_sensors        = es;
      row.tick.limit_switch       = ls;
      row.tick.rail_position      = pos;
      row.tick.coin_rightward     = cr;
      row.tick.coin_leftward      = cl;
      row.tick.drive_enable       = en;
      row.reps                    = reps;
      row.pinned                  = pinned;
      row.pin.speed_setpoint      = speed[13:0];
      row.pin.drive_active        = active;
      tick_plan.push_back(row);
   endtask

   // Random patrol: mostly runs toward a feint point with coins mostly set,
   // end-sensor pauses, and some fully random ticks.
   task automatic patrol_phase(input int quota);
      int           sent, len, kind, gap_max;
      logic [15:0]  pos, step;
      logic         dir_left;
      rps_item_type it;
      sent = 0;
      while (sent < quota) begin
         kind          = $urandom_range(0, 99);
         gap_max       = ($urandom_range(0, 3) == 0) ? 0 : 18;
         rsp_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 18;
         dir_left      = head_left;
         pos  = dir_left ? cfg_point_left + 16'($urandom_range(0, 400))
                         : cfg_point_right - 16'($urandom_range(0, 400));
         step = 16'($urandom_range(1, 40));
         if (kind < 55) len = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400)
                                                          : $urandom_range(5, 60);
         else if (kind < 85) len = $urandom_range(1, 130);
         else len = $urandom_range(1, 8);
         for (int i = 0; i < len; i++) begin
            if (kind < 55) begin
               it.end_sensors    = ES_IDLE;
               it.limit_switch   = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 2))
                                                                : LS_NONE;
               it.rail_position  = pos;
               it.coin_rightward = ($urandom_range(0, 9) != 0);
               it.coin_leftward  = ($urandom_range(0, 9) != 0);
               it.drive_enable   = ($urandom_range(0, 19) != 0);
               pos = dir_left ? pos - step : pos + step;
            end else if (kind < 85) begin
               it.end_sensors    = 2'($urandom_range(1, 3));
               it.limit_switch   = 2'($urandom_range(0, 2));
               it.rail_position  = ($urandom_range(0, 7) == 0) ? 16'($urandom) : pos;
               it.coin_rightward = 1'($urandom);
               it.coin_leftward  = 1'($urandom);
               it.drive_enable   = ($urandom_range(0, 9) != 0);
            end else begin
               it.end_sensors    = 2'($urandom_range(0, 3));
               it.limit_switch   = 2'($urandom_range(0, 2));
               it.rail_position  = 16'($urandom);
               it.coin_rightward = 1'($urandom);
               it.coin_leftward  = 1'($urandom);
               it.drive_enable   = 1'($urandom);
            end
            send_tick(it, $urandom_range(0, gap_max), 1'b0, '0);
         end
         sent += len;
      end
   endtask

   // result side: random stall before each transaction
   initial begin
      int n;
      while (reset) @(posedge clock);
      forever begin
         n = $urandom_range(0, rsp_stall_max);
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (setpoint_queue.size() == 0) begin
            $error("unexpected transaction: speed_setpoint %0d drive_active %0b",
                   $signed(rsp_tdata[13:0]), rsp_tdata[14]);
            fault_count++;
         end else begin
            oldest_setpoint = setpoint_queue.pop_front();
            if (rsp_tdata[13:0] !== oldest_setpoint.speed_setpoint) begin
               $error("speed_setpoint: expected %0d, actual %0d",
                      oldest_setpoint.speed_setpoint, $signed(rsp_tdata[13:0]));
               fault_count++;
            end
            if (rsp_tdata[14] !== oldest_setpoint.drive_active) begin
               $error("drive_active: expected %0b, actual %0b",
                      oldest_setpoint.drive_active, rsp_tdata[14]);
               fault_count++;
            end
         end
      end
   end

   initial begin
      cfg_left_edge   = LEFT_SLOW_EDGE_RST;
      cfg_right_edge  = RIGHT_SLOW_EDGE_RST;
      cfg_point_right = FEINT_POINT_RIGHTWARD_RST;
      cfg_point_left  = FEINT_POINT_LEFTWARD_RST;
      cfg_pause_len   = PAUSE_TICKS_RST;
      pause_cnt = '0; run_cnt = '0; last_pos = '0; held_sp = '0;
      head_left = 1'b0; feint_r_busy = 1'b0; feint_l_busy = 1'b0;
      feint_r_cnt = '0; feint_l_cnt = '0;

      //        es        ls        pos       cr cl en reps   pin  speed  act
      plan_row(ES_IDLE,  LS_NONE,  16'd10000, 0, 0, 0, 1,     1,   0,     0);
      plan_row(ES_BOTH,  LS_NONE,  16'd10000, 0, 0, 1, 1,     1,   0,     1);
      plan_row(ES_LEFT,  LS_NONE,  16'd10000, 0, 0, 1, 101,   0,   0,     0);
      plan_row(ES_RIGHT, LS_LEFT,  16'd10000, 0, 0, 1, 1,     1,   1500,  1);
      plan_row(ES_BOTH,  LS_RIGHT, 16'd10000, 0, 0, 1, 1,     1,   -1500, 1);
      plan_row(ES_IDLE,  LS_NONE,  16'd10000, 0, 0, 1, 900,   0,   0,     0);
      plan_row(ES_IDLE,  LS_NONE,  16'd0,     0, 0, 1, 1,     1,   -1500, 1);
      plan_row(ES_IDLE,  LS_NONE,  16'hFFFF,  1, 1, 1, 1,     0,   0,     0);
      plan_row(ES_RIGHT, LS_NONE,  16'hFFFF,  0, 0, 1, 102,   0,   0,     0);
      plan_row(ES_LEFT,  LS_NONE,  16'hFFFF,  0, 0, 1, 102,   0,   0,     0);
      plan_row(ES_IDLE,  LS_NONE,  16'hFFFF,  0, 0, 1, 1,     1,   1500,  1);
      // full rightward feint, then full leftward feint
      plan_row(ES_IDLE,  LS_NONE,  16'd14000, 0, 0, 1, 1,     0,   0,     0);
      plan_row(ES_IDLE,  LS_NONE,  16'd14200, 1, 0, 1, 1010,  0,   0,     0);
      plan_row(ES_IDLE,  LS_NONE,  16'd9000,  0, 0, 1, 1,     0,   0,     0);
      plan_row(ES_IDLE,  LS_NONE,  16'd8999,  0, 1, 1, 1010,  0,   0,     0);
      // run and pause counters past full scale
      plan_row(ES_IDLE,  LS_NONE,  16'd10000, 0, 0, 1, 65600, 0,   0,     0);
      plan_row(ES_LEFT,  LS_NONE,  16'd10000, 0, 0, 1, 65600, 0,   0,     0);
      plan_row(ES_IDLE,  LS_RIGHT, 16'd10000, 1, 1, 0, 1,     1,   0,     0);
      plan_row(ES_BOTH,  LS_LEFT,  16'd0,     1, 0, 1, 1,     0,   0,     0);
      plan_row(ES_IDLE,  LS_NONE,  16'd0,     0, 0, 1, 1,     0,   0,     0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (tick_plan[r]) begin
         rsp_stall_max = (tick_plan[r].reps == 1) ? 18 : 0;
         for (int i = 0; i < tick_plan[r].reps; i++)
            send_tick(tick_plan[r].tick, (tick_plan[r].reps == 1) ? $urandom_range(0, 18) : 0,
                      tick_plan[r].pinned, tick_plan[r].pin);
      end
      settle();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: load_settings(LEFT_SLOW_EDGE_RST, RIGHT_SLOW_EDGE_RST,
                             FEINT_POINT_RIGHTWARD_RST, FEINT_POINT_LEFTWARD_RST,
                             PAUSE_TICKS_RST);
            1: load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd1);
            2: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            3: load_settings(16'($urandom_range(30000, 50000)), 16'($urandom_range(5000, 29999)),
                             16'($urandom), 16'($urandom), 16'($urandom_range(1, 150)));
            default: load_settings(16'($urandom_range(0, 12000)),
                                   16'($urandom_range(12000, 40000)),
                                   16'($urandom_range(8000, 30000)),
                                   16'($urandom_range(2000, 20000)),
                                   16'($urandom_range(1, 150)));
         endcase
         patrol_phase(225);
         settle();
      end

      repeat (6) @(posedge clock);
      if (fault_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
